// File: sv/gia_pkg.sv
// ----------------------------------------------------------------------------
// gia_pkg: shared types and constants of the generational id allocator
// Holds the field widths, the operation and status codes, the controller
// states and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package gia_pkg;

  // Default sizing of the allocator.
  localparam int DEF_MAX_IDS  = 1024;
  localparam int DEF_GEN_BITS = 32;

  // Fixed widths of the port fields.
  localparam int OP_W        = 3;
  localparam int ID_FIELD_W  = 10;
  localparam int CNT_FIELD_W = 11;
  localparam int GEN_FIELD_W = 32;
  localparam int STATUS_W    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE  = 3'd0,
    OP_DESTROY = 3'd1,
    OP_QUERY   = 3'd2,
    OP_RANGE   = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_ALIVE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP_FILL,
    S_SCAN_RD,
    S_SCAN_CHK
  } state_t;

  // Source of the entry table read address.
  typedef enum logic [1:0] {
    RD_INPUT,
    RD_STACK,
    RD_SCAN
  } rd_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;
    logic    exec;
    logic    pop_fill;
    logic    scan_rd;
    logic    scan_chk;
    rd_sel_t rd_sel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic stack_empty;
    logic scan_more;
  } sts_t;

endpackage

// File: sv/generational_id_allocator.sv
// ----------------------------------------------------------------------------
// generational_id_allocator: allocator of ids with generation counters
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// Usage: an operation beat is taken at a rising edge where start is high and
// busy is low; in_op selects create, destroy, query, destroy range or clear,
// in_entity_id names the id (or the first id of a range) and in_range_end the
// exclusive end of a range. Each operation gives exactly one result beat on
// the out_ ports, marked by out_valid for a single cycle. The receiver cannot
// stall, so the result must be taken in that cycle.
// Sequence of states after the accepting edge: create of a never-used id,
// destroy, query, clear and unused codes pass through the execute state and
// then strobe; create that reuses a freed id adds a pop-fill state, since the
// free stack read is followed by a generation read of the entry table. Destroy
// range walks the ids from the first id up to the lesser of the saturated end
// and the number of ids ever handed out: each id needs one entry table read
// and one check-and-write, and one last read step ends the walk. busy drops in
// the strobe cycle, so the next operation can be taken at the edge that ends it.
// Reset (synchronous, rst_n low) empties the pool at once with no clearing
// pass; table entries are only read after they were written by a create.
// ----------------------------------------------------------------------------
module generational_id_allocator #(
  parameter int MAX_IDS  = gia_pkg::DEF_MAX_IDS,
  parameter int GEN_BITS = gia_pkg::DEF_GEN_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [gia_pkg::OP_W-1:0]          in_op,
  input  logic [gia_pkg::ID_FIELD_W-1:0]    in_entity_id,
  input  logic [gia_pkg::CNT_FIELD_W-1:0]   in_range_end,
  output logic                              out_valid,
  output logic [gia_pkg::STATUS_W-1:0]      out_status,
  output logic [gia_pkg::ID_FIELD_W-1:0]    out_result_id,
  output logic                              out_alive_flag,
  output logic [gia_pkg::GEN_FIELD_W-1:0]   out_generation,
  output logic [gia_pkg::CNT_FIELD_W-1:0]   out_destroyed_count,
  output logic [gia_pkg::CNT_FIELD_W-1:0]   out_live_count
);
  import gia_pkg::*;

  // Commands flow from the controller, status back from the datapath.
  cmd_t cmd;
  sts_t sts;

  gia_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // The datapath owns both memories, the counters and the result registers.
  gia_dp #(
    .MAX_IDS  (MAX_IDS),
    .GEN_BITS (GEN_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_op               (in_op),
    .in_entity_id        (in_entity_id),
    .in_range_end        (in_range_end),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_result_id       (out_result_id),
    .out_alive_flag      (out_alive_flag),
    .out_generation      (out_generation),
    .out_destroyed_count (out_destroyed_count),
    .out_live_count      (out_live_count)
  );

endmodule

// File: sv/gia_ctrl.sv
// ----------------------------------------------------------------------------
// gia_ctrl: controller of the generational id allocator
// Sequences one operation at a time and issues datapath commands.
// ----------------------------------------------------------------------------
module gia_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  gia_pkg::sts_t sts,
  output gia_pkg::cmd_t cmd
);
  import gia_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.op)
          OP_CREATE: begin
            state_nxt = sts.stack_empty ? S_IDLE : S_POP_FILL;
          end
          OP_RANGE: begin
            state_nxt = S_SCAN_RD;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_POP_FILL: begin
        state_nxt = S_IDLE;
      end
      S_SCAN_RD: begin
        state_nxt = sts.scan_more ? S_SCAN_CHK : S_IDLE;
      end
      S_SCAN_CHK: begin
        state_nxt = S_SCAN_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd          = '0;
    cmd.rd_sel   = RD_INPUT;
    busy         = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        cmd.rd_sel = RD_STACK;
      end
      S_POP_FILL: begin
        cmd.pop_fill = 1'b1;
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        cmd.rd_sel  = RD_SCAN;
      end
      S_SCAN_CHK: begin
        cmd.scan_chk = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

`ifndef ASSERT_OFF
  // A popped id is always filled right after the operation step.
  a_pop_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP_FILL) |-> $past(state_r == S_EXEC))
    else $error("pop fill not preceded by execute");

  // A scan check always follows a scan read that found more ids.
  a_chk_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_CHK) |-> ($past(state_r == S_SCAN_RD) && $past(sts.scan_more)))
    else $error("scan check without pending id");

  // Nothing is accepted while an operation is in progress.
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> (state_r == S_IDLE))
    else $error("accept outside idle");
`endif

endmodule

// File: sv/gia_dp.sv
// ----------------------------------------------------------------------------
// gia_dp: datapath of the generational id allocator
// Holds the entry table (alive mark and generation), the free stack, the
// counters and the result registers, and acts on controller commands.
// ----------------------------------------------------------------------------
module gia_dp #(
  parameter int MAX_IDS  = gia_pkg::DEF_MAX_IDS,
  parameter int GEN_BITS = gia_pkg::DEF_GEN_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gia_pkg::cmd_t                     cmd,
  output gia_pkg::sts_t                     sts,
  input  logic [gia_pkg::OP_W-1:0]          in_op,
  input  logic [gia_pkg::ID_FIELD_W-1:0]    in_entity_id,
  input  logic [gia_pkg::CNT_FIELD_W-1:0]   in_range_end,
  output logic                              out_valid,
  output logic [gia_pkg::STATUS_W-1:0]      out_status,
  output logic [gia_pkg::ID_FIELD_W-1:0]    out_result_id,
  output logic                              out_alive_flag,
  output logic [gia_pkg::GEN_FIELD_W-1:0]   out_generation,
  output logic [gia_pkg::CNT_FIELD_W-1:0]   out_destroyed_count,
  output logic [gia_pkg::CNT_FIELD_W-1:0]   out_live_count
);
  import gia_pkg::*;

  localparam int ID_W   = $clog2(MAX_IDS);
  localparam int CW_RAW = $clog2(MAX_IDS + 1);
  localparam int CNT_W  = (CW_RAW > CNT_FIELD_W) ? CW_RAW : CNT_FIELD_W;
  localparam int IDX_W  = (ID_W > ID_FIELD_W) ? ID_W : ID_FIELD_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_IDS);

  // Storage: entry word is {alive, generation}.
  logic [GEN_BITS:0] entry_mem [MAX_IDS];
  logic [ID_W-1:0]   stack_mem [MAX_IDS];
  logic [GEN_BITS:0] ent_rdata_r;
  logic [ID_W-1:0]   stk_rdata_r;

  logic              ent_we;
  logic [ID_W-1:0]   ent_waddr;
  logic [GEN_BITS:0] ent_wdata;
  logic [ID_W-1:0]   ent_raddr;
  logic              stk_we;
  logic [ID_W-1:0]   stk_waddr;
  logic [ID_W-1:0]   stk_wdata;
  logic [ID_W-1:0]   stk_raddr;

  // Control state.
  logic [CNT_W-1:0] top_r, top_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0] alive_total_r, alive_total_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Operation and result registers.
  op_t               op_r, op_nxt;
  logic [IDX_W-1:0]  id_r, id_nxt;
  logic [CNT_W-1:0]  last_r, last_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [IDX_W-1:0]  rid_r, rid_nxt;
  status_t           status_r, status_nxt;
  logic              alive_flag_r, alive_flag_nxt;
  logic [GEN_BITS-1:0] gen_r, gen_nxt;
  logic [CNT_W-1:0]  destroyed_r, destroyed_nxt;

  logic [IDX_W-1:0]    in_id_ext;
  logic [CNT_W-1:0]    in_end_ext;
  logic [CNT_W-1:0]    top_m1;
  logic                id_in_range;
  logic                ent_alive;
  logic [GEN_BITS-1:0] ent_gen;
  logic [GEN_BITS-1:0] ent_gen_inc;
  logic                scan_more;

  assign in_id_ext   = IDX_W'(in_entity_id);
  assign in_end_ext  = CNT_W'(in_range_end);
  assign top_m1      = top_r - 1'b1;
  assign id_in_range = CNT_W'(id_r) < used_r;
  assign ent_alive   = ent_rdata_r[GEN_BITS];
  assign ent_gen     = ent_rdata_r[GEN_BITS-1:0];
  assign ent_gen_inc = ent_gen + 1'b1;
  assign scan_more   = (k_r < last_r) && (k_r < used_r);
  assign stk_raddr   = top_m1[ID_W-1:0];

  always_comb begin
    case (cmd.rd_sel)
      RD_STACK: ent_raddr = stk_rdata_r;
      RD_SCAN:  ent_raddr = k_r[ID_W-1:0];
      default:  ent_raddr = in_id_ext[ID_W-1:0];
    endcase
  end

  assign sts.op          = op_r;
  assign sts.stack_empty = (top_r == '0);
  assign sts.scan_more   = scan_more;

  // Memories with registered read data.
  always_ff @(posedge clk) begin
    if (ent_we) begin
      entry_mem[ent_waddr] <= ent_wdata;
    end
    ent_rdata_r <= entry_mem[ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    stk_rdata_r <= stack_mem[stk_raddr];
  end

  always_comb begin
    top_nxt         = top_r;
    used_nxt        = used_r;
    alive_total_nxt = alive_total_r;
    out_valid_nxt   = 1'b0;
    op_nxt          = op_r;
    id_nxt          = id_r;
    last_nxt        = last_r;
    k_nxt           = k_r;
    rid_nxt         = rid_r;
    status_nxt      = status_r;
    alive_flag_nxt  = alive_flag_r;
    gen_nxt         = gen_r;
    destroyed_nxt   = destroyed_r;
    ent_we          = 1'b0;
    ent_waddr       = id_r[ID_W-1:0];
    ent_wdata       = {1'b0, ent_gen_inc};
    stk_we          = 1'b0;
    stk_waddr       = top_r[ID_W-1:0];
    stk_wdata       = id_r[ID_W-1:0];

    if (cmd.accept) begin
      op_nxt   = op_t'(in_op);
      id_nxt   = in_id_ext;
      k_nxt    = CNT_W'(in_entity_id);
      last_nxt = (in_end_ext > MAX_CNT) ? MAX_CNT : in_end_ext;
    end

    if (cmd.exec) begin
      rid_nxt        = id_r;
      status_nxt     = ST_OK;
      alive_flag_nxt = 1'b0;
      gen_nxt        = '0;
      destroyed_nxt  = '0;
      out_valid_nxt  = 1'b1;
      case (op_r)
        OP_CREATE: begin
          if (top_r != '0) begin
            // Reuse the most recently freed id; its generation is read next.
            // The id leaves the stack and joins the live count together.
            top_nxt         = top_m1;
            alive_total_nxt = alive_total_r + 1'b1;
            rid_nxt         = IDX_W'(stk_rdata_r);
            out_valid_nxt   = 1'b0;
          end else if (used_r < MAX_CNT) begin
            rid_nxt         = IDX_W'(used_r);
            ent_we          = 1'b1;
            ent_waddr       = used_r[ID_W-1:0];
            ent_wdata       = {1'b1, {GEN_BITS{1'b0}}};
            used_nxt        = used_r + 1'b1;
            alive_total_nxt = alive_total_r + 1'b1;
          end else begin
            status_nxt = ST_FULL;
            rid_nxt    = '0;
          end
        end
        OP_DESTROY: begin
          if (id_in_range && ent_alive) begin
            ent_we          = 1'b1;
            stk_we          = 1'b1;
            top_nxt         = top_r + 1'b1;
            alive_total_nxt = alive_total_r - 1'b1;
            gen_nxt         = ent_gen_inc;
          end else begin
            status_nxt = ST_NOT_ALIVE;
            gen_nxt    = id_in_range ? ent_gen : '0;
          end
        end
        OP_QUERY: begin
          alive_flag_nxt = id_in_range && ent_alive;
          gen_nxt        = id_in_range ? ent_gen : '0;
        end
        OP_RANGE: begin
          out_valid_nxt = 1'b0;
        end
        OP_CLEAR: begin
          top_nxt         = '0;
          used_nxt        = '0;
          alive_total_nxt = '0;
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end

    if (cmd.pop_fill) begin
      ent_we          = 1'b1;
      ent_waddr       = rid_r[ID_W-1:0];
      ent_wdata       = {1'b1, ent_gen};
      gen_nxt         = ent_gen;
      out_valid_nxt   = 1'b1;
    end

    if (cmd.scan_rd && !scan_more) begin
      out_valid_nxt = 1'b1;
    end

    if (cmd.scan_chk) begin
      if (ent_alive) begin
        ent_we          = 1'b1;
        ent_waddr       = k_r[ID_W-1:0];
        stk_we          = 1'b1;
        stk_wdata       = k_r[ID_W-1:0];
        top_nxt         = top_r + 1'b1;
        alive_total_nxt = alive_total_r - 1'b1;
        destroyed_nxt   = destroyed_r + 1'b1;
      end
      k_nxt = k_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r         <= '0;
      used_r        <= '0;
      alive_total_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      top_r         <= top_nxt;
      used_r        <= used_nxt;
      alive_total_r <= alive_total_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    last_r       <= last_nxt;
    k_r          <= k_nxt;
    rid_r        <= rid_nxt;
    status_r     <= status_nxt;
    alive_flag_r <= alive_flag_nxt;
    gen_r        <= gen_nxt;
    destroyed_r  <= destroyed_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_result_id       = rid_r[ID_FIELD_W-1:0];
  assign out_alive_flag      = alive_flag_r;
  assign out_generation      = GEN_FIELD_W'(gen_r);
  assign out_destroyed_count = destroyed_r[CNT_FIELD_W-1:0];
  assign out_live_count      = alive_total_r[CNT_FIELD_W-1:0];

`ifndef ASSERT_OFF
  // Every used id is either alive or waiting on the free stack.
  a_id_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W'(top_r + alive_total_r) == used_r))
    else $error("free stack and live count do not add up to used ids");

  // Never more ids handed out than the pool holds.
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r <= MAX_CNT))
    else $error("used count beyond capacity");

  // A scan only ever checks entries that have been written.
  a_scan_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_chk |-> (k_r < used_r))
    else $error("scan beyond used ids");

  // Results never come in two consecutive cycles.
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("back to back result strobes");
`endif

endmodule

// File: dv/gia_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gia_checker: result predictor and scoreboard for the id allocator
// Watches the operation and result channels, keeps its own copy of the id
// pool to work out each expected result beat, and compares every result beat
// field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module gia_checker
  import gia_pkg::*;
#(
  parameter int MAX_IDS = DEF_MAX_IDS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   busy,
  input  logic [OP_W-1:0]        in_op,
  input  logic [ID_FIELD_W-1:0]  in_entity_id,
  input  logic [CNT_FIELD_W-1:0] in_range_end,
  input  logic                   out_valid,
  input  logic [STATUS_W-1:0]    out_status,
  input  logic [ID_FIELD_W-1:0]  out_result_id,
  input  logic                   out_alive_flag,
  input  logic [GEN_FIELD_W-1:0] out_generation,
  input  logic [CNT_FIELD_W-1:0] out_destroyed_count,
  input  logic [CNT_FIELD_W-1:0] out_live_count,
  output int                     fail_count,
  output int                     outstanding
);

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [ID_FIELD_W-1:0]  result_id;
    logic                   alive_flag;
    logic [GEN_FIELD_W-1:0] generation;
    logic [CNT_FIELD_W-1:0] destroyed_count;
    logic [CNT_FIELD_W-1:0] live_count;
  } alloc_beat_t;

  // Shadow of the id pool.
  bit                    pool_alive [MAX_IDS];
  bit [GEN_FIELD_W-1:0]  pool_gen [MAX_IDS];
  bit [ID_FIELD_W-1:0]   free_ids [MAX_IDS];
  int                    free_depth = 0;
  int                    ever_used = 0;
  int                    live_ids = 0;

  alloc_beat_t           expected_beats [$];
  int                    fails = 0;

  function automatic bit is_live(int id);
    return id < ever_used && pool_alive[id];
  endfunction

  function automatic logic [GEN_FIELD_W-1:0] gen_of(int id);
    return (id < ever_used) ? pool_gen[id] : '0;
  endfunction

  function automatic void retire_id(int id);
    pool_alive[id] = 1'b0;
    pool_gen[id]   = pool_gen[id] + 1'b1;
    if (free_depth < MAX_IDS) begin
      free_ids[free_depth] = ID_FIELD_W'(id);
      free_depth++;
    end
    if (live_ids > 0) live_ids--;
  endfunction

  function automatic alloc_beat_t step_allocator(logic [OP_W-1:0] op,
                                                 logic [ID_FIELD_W-1:0] id,
                                                 logic [CNT_FIELD_W-1:0] rend);
    alloc_beat_t r;
    int          pick;
    int          stop;
    r           = '0;
    r.status    = ST_OK;
    r.result_id = id;
    case (op)
      OP_CREATE: begin
        // The free stack is LIFO; fresh ids are only taken when it is empty.
        if (free_depth > 0) begin
          free_depth--;
          pick = free_ids[free_depth];
        end else if (ever_used < MAX_IDS) begin
          pick           = ever_used;
          pool_gen[pick] = '0;
          pool_alive[pick] = 1'b0;
          ever_used++;
        end else begin
          pick = -1;
        end
        if (pick < 0) begin
          r.status    = ST_FULL;
          r.result_id = '0;
        end else begin
          if (!pool_alive[pick]) live_ids++;
          pool_alive[pick] = 1'b1;
          r.result_id      = ID_FIELD_W'(pick);
          r.generation     = pool_gen[pick];
        end
      end
      OP_DESTROY: begin
        if (is_live(id)) retire_id(id);
        else r.status = ST_NOT_ALIVE;
        r.generation = gen_of(id);
      end
      OP_QUERY: begin
        r.alive_flag = is_live(id);
        r.generation = gen_of(id);
      end
      OP_RANGE: begin
        stop = (rend > MAX_IDS) ? MAX_IDS : rend;
        for (int k = id; k < stop; k++) begin
          if (is_live(k)) begin
            retire_id(k);
            r.destroyed_count = r.destroyed_count + 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        free_depth = 0;
        ever_used  = 0;
        live_ids   = 0;
      end
      default: ;
    endcase
    r.live_count = CNT_FIELD_W'(live_ids);
    return r;
  endfunction

  function automatic void show_beat(string tag, alloc_beat_t b);
    $display("  %s: status=%0d id=%0d alive=%0d gen=%0d destroyed=%0d live=%0d",
             tag, b.status, b.result_id, b.alive_flag, b.generation,
             b.destroyed_count, b.live_count);
  endfunction

  always @(posedge clk) begin
    alloc_beat_t got;
    alloc_beat_t want;
    if (rst_n) begin
      if (out_valid) begin
        got = '{status: out_status, result_id: out_result_id,
                alive_flag: out_alive_flag, generation: out_generation,
                destroyed_count: out_destroyed_count, live_count: out_live_count};
        if (expected_beats.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("%0t: result beat with nothing expected", $realtime);
            show_beat("actual", got);
          end
        end else begin
          want = expected_beats.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: result beat mismatch", $realtime);
              show_beat("expected", want);
              show_beat("actual", got);
            end
          end
        end
      end
      if (start && !busy)
        expected_beats = {expected_beats,
                          step_allocator(in_op, in_entity_id, in_range_end)};
    end
    fail_count  <= fails;
    outstanding <= expected_beats.size();
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench top of the generational id allocator
// Drives operation beats into the allocator, directed first and then random,
// under three idling patterns, and leaves the checking to gia_checker, which
// sits beside the block and reports its failure count back for the verdict.
// ----------------------------------------------------------------------------
module tb;
  import gia_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 8;
  localparam int TAIL_CYCLES    = 16;
  localparam int TIMEOUT_CYCLES = 16000000;
  localparam int CHURN_BEATS    = 90;
  localparam int FILL_BEATS     = DEF_MAX_IDS + 6;
  localparam int SWEEP_BEATS    = 120;
  localparam int LAST_ID        = DEF_MAX_IDS - 1;
  localparam int LAST_END       = (1 << CNT_FIELD_W) - 1;

  // Codes 5 to 7 are not operations; the block must answer them harmlessly.
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [OP_W-1:0]        in_op;
  logic [ID_FIELD_W-1:0]  in_entity_id;
  logic [CNT_FIELD_W-1:0] in_range_end;
  logic                   out_valid;
  logic [STATUS_W-1:0]    out_status;
  logic [ID_FIELD_W-1:0]  out_result_id;
  logic                   out_alive_flag;
  logic [GEN_FIELD_W-1:0] out_generation;
  logic [CNT_FIELD_W-1:0] out_destroyed_count;
  logic [CNT_FIELD_W-1:0] out_live_count;

  int mismatches;
  int pending;

  // Chance, in percent, that the sender idles before a beat, drawn anew while it idles.
  int idle_pct;
  // Creates issued since the last clear, capped at the pool size. Ids are
  // handed out from zero upward, so this is a rough ceiling on the ids that
  // have ever been used; destroys and queries aim below it most of the time
  // so that they hit live ids instead of bouncing off as not alive.
  int create_hint;

  generational_id_allocator dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_op               (in_op),
    .in_entity_id        (in_entity_id),
    .in_range_end        (in_range_end),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_result_id       (out_result_id),
    .out_alive_flag      (out_alive_flag),
    .out_generation      (out_generation),
    .out_destroyed_count (out_destroyed_count),
    .out_live_count      (out_live_count)
  );

  gia_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_op               (in_op),
    .in_entity_id        (in_entity_id),
    .in_range_end        (in_range_end),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_result_id       (out_result_id),
    .out_alive_flag      (out_alive_flag),
    .out_generation      (out_generation),
    .out_destroyed_count (out_destroyed_count),
    .out_live_count      (out_live_count),
    .fail_count          (mismatches),
    .outstanding         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Hard stop in case the block hangs or never answers a beat.
  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("simulation failed");
    $finish;
  end

  // Presents one operation beat and returns at the edge that accepts it.
  // Busy is read right after the edge, so it is the value the block showed
  // at that edge. Start stays high into the next beat unless the sender idles,
  // which it does at random before raising start again.
  task automatic issue_op(input logic [OP_W-1:0] op, input int id, input int rend);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_op        <= op;
    in_entity_id <= ID_FIELD_W'(id);
    in_range_end <= CNT_FIELD_W'(rend);
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == OP_CREATE && create_hint < DEF_MAX_IDS) create_hint++;
    if (op == OP_CLEAR) create_hint = 0;
  endtask

  // Lowers start and waits until every beat issued so far has been answered.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic int pick_id();
    if (create_hint > 0 && $urandom_range(0, 99) < 85)
      return $urandom_range(0, create_hint - 1);
    return $urandom_range(0, LAST_ID);
  endfunction

  // Range ends: mostly short windows, some empty or reversed ones, some that
  // run past the pool and must be saturated.
  function automatic int pick_end(input int first);
    int shape;
    shape = $urandom_range(0, 99);
    if (shape < 70) return first + $urandom_range(0, 16);
    if (shape < 80) return $urandom_range(0, first);
    if (shape < 90) return $urandom_range(DEF_MAX_IDS, LAST_END);
    return $urandom_range(0, LAST_END);
  endfunction

  // One random beat of everyday traffic: creates outweigh destroys so the
  // pool grows slowly, and freed ids come back through the LIFO stack.
  task automatic churn_beat();
    int sel;
    int id;
    sel = $urandom_range(0, 99);
    id  = pick_id();
    if (sel < 38)
      issue_op(OP_CREATE, $urandom_range(0, LAST_ID), $urandom_range(0, LAST_END));
    else if (sel < 63)
      issue_op(OP_DESTROY, id, $urandom_range(0, LAST_END));
    else if (sel < 81)
      issue_op(OP_QUERY, id, $urandom_range(0, LAST_END));
    else if (sel < 93)
      issue_op(OP_RANGE, id, pick_end(id));
    else if (sel < 95)
      issue_op(OP_CLEAR, $urandom_range(0, LAST_ID), $urandom_range(0, LAST_END));
    else
      issue_op(OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
               $urandom_range(0, LAST_ID), $urandom_range(0, LAST_END));
  endtask

  initial begin
    int sel;
    int id;
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_op        <= OP_CREATE;
    in_entity_id <= '0;
    in_range_end <= '0;
    idle_pct     = 8;
    create_hint  = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening. Ids that were never handed out are queried and
    // destroyed before anything exists, then a small pool is built so that
    // a double destroy, the generation bump and LIFO reuse are all visible.
    issue_op(OP_QUERY, 0, 0);
    issue_op(OP_DESTROY, 0, 0);
    issue_op(OP_CREATE, 0, 0);
    issue_op(OP_CREATE, 0, 0);
    issue_op(OP_CREATE, 0, 0);
    issue_op(OP_QUERY, 1, 0);
    issue_op(OP_DESTROY, 1, 0);
    issue_op(OP_DESTROY, 1, 0);
    issue_op(OP_QUERY, 1, 0);
    issue_op(OP_CREATE, 0, 0);
    issue_op(OP_DESTROY, 0, 0);
    issue_op(OP_DESTROY, 2, 0);
    issue_op(OP_CREATE, 0, 0);
    // Reversed and empty ranges, then one whose end saturates at the pool size.
    issue_op(OP_RANGE, 5, 3);
    issue_op(OP_RANGE, 2, 2);
    issue_op(OP_RANGE, 0, LAST_END);
    issue_op(OP_SPARE_FIRST, LAST_ID, LAST_END);
    issue_op(OP_SPARE_FIRST + 3'd1, 0, 0);
    issue_op(OP_SPARE_LAST, LAST_ID, DEF_MAX_IDS);
    issue_op(OP_QUERY, LAST_ID, LAST_END);
    issue_op(OP_DESTROY, LAST_ID, 0);
    issue_op(OP_CLEAR, LAST_ID, LAST_END);
    issue_op(OP_CREATE, LAST_ID, LAST_END);
    issue_op(OP_RANGE, LAST_ID, DEF_MAX_IDS);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 8 : (phase == 1) ? 54 : 0;
      repeat (CHURN_BEATS) churn_beat();
      if (phase == 0) begin
        // Fill the pool to the brim from wherever churn left it, so the last
        // few creates must come back full; then sweep the whole id space with
        // destroys, queries and ranges while almost every id is live.
        drain();
        repeat (FILL_BEATS)
          issue_op(OP_CREATE, $urandom_range(0, LAST_ID), $urandom_range(0, LAST_END));
        repeat (SWEEP_BEATS) begin
          sel = $urandom_range(0, 99);
          id  = $urandom_range(0, LAST_ID);
          if (sel < 60)
            issue_op(OP_DESTROY, id, $urandom_range(0, LAST_END));
          else if (sel < 85)
            issue_op(OP_QUERY, id, $urandom_range(0, LAST_END));
          else if (sel < 95)
            issue_op(OP_RANGE, id, id + $urandom_range(0, 64));
          else
            issue_op(OP_CREATE, id, $urandom_range(0, LAST_END));
        end
      end
      repeat (CHURN_BEATS) churn_beat();
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
